>>> rtl/core/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// shared types and constants of the activity clip segmenter
// ----------------------------------------------------------------------------
package acs_pkg;

	localparam int AREA_W = 32;
	localparam int CLIP_W = 24;
	localparam int LEN_W  = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP      = 2'd2;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic              end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [CLIP_W-1:0] clip_start;
		logic [CLIP_W-1:0] clip_end;
		logic              last_clip;
	} out_word_t;

	// control part of a run event passed from front to back
	typedef struct packed {
		logic has_run;
		logic eos;
	} evt_flags_t;

endpackage

>>> rtl/core/acs_front.sv
// ----------------------------------------------------------------------------
// acs_front
// classifies frames as active, tracks runs and the frame counter, and turns
// each finished run or end of stream into an event for the back part
// ----------------------------------------------------------------------------
module acs_front #(
	parameter int INDEX_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  acs_pkg::in_word_t              in_data,
	input  logic [acs_pkg::AREA_W-1:0]     area_threshold,
	input  logic                           q_full,
	output logic                           ev_push,
	output acs_pkg::evt_flags_t            ev_flags,
	output logic [INDEX_BITS-1:0]          ev_start,
	output logic [INDEX_BITS-1:0]          ev_end
);
	import acs_pkg::*;

	localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

	logic                  prev_active_q;
	logic [INDEX_BITS-1:0] run_start_q;
	logic [INDEX_BITS-1:0] frame_q;
	logic                  accept;
	logic                  active;
	logic                  close_prev;
	logic                  close_eos;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign active   = in_data.area > area_threshold;

	// a run ends on the frame before an inactive one, or on the final frame
	assign close_prev = !active && prev_active_q;
	assign close_eos  = in_data.end_of_stream && active;

	always_comb begin
		ev_flags.has_run = close_prev || close_eos;
		ev_flags.eos     = in_data.end_of_stream;
		if (close_eos) begin
			ev_start = prev_active_q ? run_start_q : frame_q;
			ev_end   = frame_q;
		end else begin
			ev_start = run_start_q;
			ev_end   = (frame_q != '0) ? frame_q - INDEX_BITS'(1) : '0;
		end
	end

	assign ev_push = accept && (close_prev || close_eos || in_data.end_of_stream);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_active_q <= 1'b0;
			run_start_q   <= '0;
			frame_q       <= '0;
		end else if (accept) begin
			if (in_data.end_of_stream) begin
				prev_active_q <= 1'b0;
				run_start_q   <= '0;
				frame_q       <= '0;
			end else begin
				prev_active_q <= active;
				if (active && !prev_active_q) begin
					run_start_q <= frame_q;
				end
				// counter saturates at the top index
				if (frame_q != IDX_MAX) begin
					frame_q <= frame_q + INDEX_BITS'(1);
				end
			end
		end
	end

endmodule

>>> rtl/core/acs_queue.sv
// ----------------------------------------------------------------------------
// acs_queue
// short first-in first-out queue of run events between front and back
// ----------------------------------------------------------------------------
module acs_queue #(
	parameter int WIDTH = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	import acs_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/acs_back.sv
// ----------------------------------------------------------------------------
// acs_back
// filters runs by length, merges close clips into the held clip and emits
// finished clips through an output register
// ----------------------------------------------------------------------------
module acs_back #(
	parameter int INDEX_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ev_valid,
	input  acs_pkg::evt_flags_t         ev_flags,
	input  logic [INDEX_BITS-1:0]       ev_start,
	input  logic [INDEX_BITS-1:0]       ev_end,
	output logic                        ev_pop,
	input  logic [acs_pkg::LEN_W-1:0]   min_length,
	input  logic [acs_pkg::LEN_W-1:0]   merge_gap,
	output logic                        out_valid,
	input  logic                        out_ready,
	output acs_pkg::out_word_t          out_data
);
	import acs_pkg::*;

	localparam int CW = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

	logic                  pend_valid_q;
	logic [INDEX_BITS-1:0] pend_start_q;
	logic [INDEX_BITS-1:0] pend_end_q;
	logic                  phase_q;
	logic                  out_valid_q;
	out_word_t             out_data_q;

	logic                  fire;
	logic [INDEX_BITS-1:0] end_cl;
	logic [INDEX_BITS-1:0] run_len;
	logic [INDEX_BITS-1:0] gap;
	logic                  survive;
	logic                  merge;
	logic                  emit_held;
	logic                  nxt_valid;
	logic [INDEX_BITS-1:0] nxt_start;
	logic [INDEX_BITS-1:0] nxt_end;

	assign fire   = ev_valid && (!out_valid_q || out_ready);
	assign end_cl = (ev_end < ev_start) ? ev_start : ev_end;
	assign run_len = end_cl - ev_start;
	assign gap    = (ev_start >= pend_end_q) ? ev_start - pend_end_q : '0;

	// the second pass of a two-clip flush has its run already folded in
	assign survive   = ev_flags.has_run && !phase_q && !(CW'(run_len) < CW'(min_length));
	assign merge     = pend_valid_q && (CW'(gap) < CW'(merge_gap));
	assign emit_held = survive && pend_valid_q && !merge;

	always_comb begin
		nxt_valid = pend_valid_q;
		nxt_start = pend_start_q;
		nxt_end   = pend_end_q;
		if (survive) begin
			if (merge) begin
				if (end_cl > pend_end_q) begin
					nxt_end = end_cl;
				end
			end else begin
				nxt_valid = 1'b1;
				nxt_start = ev_start;
				nxt_end   = end_cl;
			end
		end
	end

	assign ev_pop    = fire && !(emit_held && ev_flags.eos);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			phase_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				priority if (emit_held) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= nxt_valid;
					phase_q      <= ev_flags.eos;
				end else if (ev_flags.eos) begin
					out_valid_q  <= nxt_valid;
					pend_valid_q <= 1'b0;
					phase_q      <= 1'b0;
				end else begin
					pend_valid_q <= nxt_valid;
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (emit_held) begin
				out_data_q.clip_start <= CLIP_W'(pend_start_q);
				out_data_q.clip_end   <= CLIP_W'(pend_end_q);
				out_data_q.last_clip  <= 1'b0;
			end else if (ev_flags.eos) begin
				out_data_q.clip_start <= CLIP_W'(nxt_start);
				out_data_q.clip_end   <= CLIP_W'(nxt_end);
				out_data_q.last_clip  <= 1'b1;
			end
			pend_start_q <= nxt_start;
			pend_end_q   <= nxt_end;
		end
	end

`ifndef SYNTHESIS
	a_phase_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> pend_valid_q)
		else $error("flush second pass without a held clip");
	a_phase_holds_event: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> ev_valid)
		else $error("flush second pass lost its event");
	a_phase_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q && fire) |=> (out_valid_q && out_data_q.last_clip))
		else $error("flush second pass did not emit the final clip");
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop |-> (!out_valid_q || out_ready))
		else $error("event retired while output register stalled");
`endif

endmodule

>>> rtl/core/activity_clip_segmenter.sv
// ----------------------------------------------------------------------------
// activity_clip_segmenter
// finds clips of frames whose motion area exceeds a threshold, drops short
// runs, merges close runs and emits one clip word per finished clip
// ----------------------------------------------------------------------------
// flow: the accepting word puts its event into the event queue, and the clip
//   then leaves through the output register when it and the queue are free
// throughput: one input word per cycle while the event queue is not full; an
//   end-of-stream word that flushes two clips takes a second back-part pass,
//   absorbed by the four-entry event queue
// reset: arst_n clears counters, run tracking, held clip, queue and registers
module activity_clip_segmenter #(
	parameter int INDEX_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wen,
	input  logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acs_pkg::CFG_DATA_W-1:0] cfg_data,
	// frame words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  acs_pkg::in_word_t              in_data,
	// clip words
	output logic                           out_valid,
	input  logic                           out_ready,
	output acs_pkg::out_word_t             out_data
);
	import acs_pkg::*;

	localparam int EV_W = 2 + 2 * INDEX_BITS;

	// configuration registers
	logic [AREA_W-1:0] area_threshold_q;
	logic [LEN_W-1:0]  min_length_q;
	logic [LEN_W-1:0]  merge_gap_q;

	// front to queue
	logic                  ev_push;
	evt_flags_t            ev_flags_in;
	logic [INDEX_BITS-1:0] ev_start_in;
	logic [INDEX_BITS-1:0] ev_end_in;
	logic                  q_full;

	// queue to back
	logic                  q_head_valid;
	logic [EV_W-1:0]       q_head_data;
	logic                  q_pop;
	evt_flags_t            ev_flags_out;
	logic [INDEX_BITS-1:0] ev_start_out;
	logic [INDEX_BITS-1:0] ev_end_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_threshold_q <= '0;
			min_length_q     <= '0;
			merge_gap_q      <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_AREA_THRESHOLD: area_threshold_q <= AREA_W'(cfg_data);
				CFG_MIN_LENGTH:     min_length_q     <= LEN_W'(cfg_data);
				CFG_MERGE_GAP:      merge_gap_q      <= LEN_W'(cfg_data);
				default: begin
					// unused index, write ignored
				end
			endcase
		end
	end

	// front: active detection, run tracking, frame counter
	acs_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.area_threshold (area_threshold_q),
		.q_full         (q_full),
		.ev_push        (ev_push),
		.ev_flags       (ev_flags_in),
		.ev_start       (ev_start_in),
		.ev_end         (ev_end_in)
	);

	// event queue decouples run tracking from clip emission
	acs_queue #(
		.WIDTH(EV_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (ev_push),
		.push_data  ({ev_flags_in, ev_start_in, ev_end_in}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head_data)
	);

	assign ev_flags_out = q_head_data[EV_W-1 -: 2];
	assign ev_start_out = q_head_data[2*INDEX_BITS-1 -: INDEX_BITS];
	assign ev_end_out   = q_head_data[INDEX_BITS-1:0];

	// back: length filter, merge with held clip, output register
	acs_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_valid   (q_head_valid),
		.ev_flags   (ev_flags_out),
		.ev_start   (ev_start_out),
		.ev_end     (ev_end_out),
		.ev_pop     (q_pop),
		.min_length (min_length_q),
		.merge_gap  (merge_gap_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
